### sv/rpcs_pkg.sv
// shared constants and types for the row pair cosine similarity core
`default_nettype none
package rpcs_pkg;

    localparam int ROW_CNT_DEF     = 64;
    localparam int COL_CNT_DEF     = 256;
    localparam int RATING_BITS_DEF = 16;

    localparam int ROW_W     = 6;
    localparam int COL_W     = 8;
    localparam int RATING_W  = 16;
    localparam int CFG_W     = 9;
    localparam int SIM_W     = 16;
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q14   = 16384;

    localparam logic [CFG_W-1:0] CFG_COLS_RESET = 9'd256;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        UOP_SQRT,
        UOP_MUL,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef enum logic [1:0] {
        ACC_SA,
        ACC_SB,
        ACC_DOT
    } t_acc_sel;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RDA,
        S_RDB,
        S_MAA,
        S_MBB,
        S_MAB,
        S_DRAIN,
        S_CHK,
        S_SQA,
        S_SQA_W,
        S_SQB,
        S_SQB_W,
        S_MUL,
        S_MUL_W,
        S_DIV,
        S_DIV_W,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

### sv/rpcs_in_if.sv
// request channel: rating writes and row pair queries
`default_nettype none
interface rpcs_in_if
    import rpcs_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [ROW_W-1:0]           row_a;
    logic [COL_W-1:0]           column;
    logic signed [RATING_W-1:0] rating;
    logic [ROW_W-1:0]           row_b;

    modport source (output valid, op, row_a, column, rating, row_b, input ready);
    modport sink   (input valid, op, row_a, column, rating, row_b, output ready);
endinterface
`default_nettype wire

### sv/rpcs_out_if.sv
// result channel: similarity and zero norm flag
`default_nettype none
interface rpcs_out_if
    import rpcs_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;

    modport source (output valid, similarity, zero_norm, input ready);
    modport sink   (input valid, similarity, zero_norm, output ready);
endinterface
`default_nettype wire

### sv/rpcs_ram.sv
// generic single write port ram with registered read
`default_nettype none
module rpcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### sv/rpcs_serial_unit.sv
// shared serial unit: integer square root, shift-add multiply, restoring divide
`default_nettype none
module rpcs_serial_unit
    import rpcs_pkg::*;
#(
    parameter int ACC_W = 2 * RATING_BITS_DEF + $clog2(COL_CNT_DEF)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_unit_ctl                          i_ctl,
    output t_unit_sts                               o_sts,
    input  wire logic [ACC_W+FRAC_BITS-1:0]         i_opnd_w,
    input  wire logic [2*((ACC_W+1)/2)-1:0]         i_opnd_d,
    output logic      [ACC_W+FRAC_BITS-1:0]         o_result
);
    localparam int SQ_W  = (ACC_W + 1) / 2;
    localparam int DEN_W = 2 * SQ_W;
    localparam int NUM_W = ACC_W + FRAC_BITS;
    localparam int SW    = DEN_W + 1;
    localparam int SH    = NUM_W - DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    t_unit_op         r_op;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_w;
    logic [SW-1:0]    r_r;
    logic [NUM_W-1:0] r_res;
    logic [DEN_W-1:0] r_d;

    logic [SW-1:0]    s_min;
    logic [SW-1:0]    s_sub;
    logic [SW:0]      s_diff;
    logic             s_ge;
    logic [DEN_W-1:0] s_sum;

    always_comb begin
        case (r_op)
            UOP_SQRT: begin
                s_min = {r_r[SW-3:0], r_w[NUM_W-1 -: 2]};
                s_sub = SW'({r_res[SQ_W-1:0], 2'b01});
            end
            UOP_DIV: begin
                s_min = {r_r[SW-2:0], r_w[NUM_W-1]};
                s_sub = SW'(r_d);
            end
            default: begin
                s_min = r_r;
                s_sub = '0;
            end
        endcase
        s_diff = {1'b0, s_min} - {1'b0, s_sub};
        s_ge   = !s_diff[SW];
        s_sum  = r_res[DEN_W-1:0] + r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_ctl.op == UOP_DIV) ? CNT_W'(NUM_W) : CNT_W'(SQ_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_r   <= '0;
            r_res <= '0;
            r_d   <= i_opnd_d;
            r_w   <= (i_ctl.op == UOP_SQRT) ? (i_opnd_w << SH) : i_opnd_w;
        end else if (r_busy) begin
            case (r_op)
                UOP_SQRT: begin
                    r_r   <= s_ge ? s_diff[SW-1:0] : s_min;
                    r_res <= {r_res[NUM_W-2:0], s_ge};
                    r_w   <= r_w << 2;
                end
                UOP_DIV: begin
                    r_r   <= s_ge ? s_diff[SW-1:0] : s_min;
                    r_res <= {r_res[NUM_W-2:0], s_ge};
                    r_w   <= r_w << 1;
                end
                UOP_MUL: begin
                    if (r_w[0]) begin
                        r_res <= NUM_W'(s_sum);
                    end
                    r_d <= r_d << 1;
                    r_w <= r_w >> 1;
                end
                default: begin
                    r_r <= r_r;
                end
            endcase
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_res;
endmodule
`default_nettype wire

### sv/row_pair_cosine_similarity_core.sv
// top level: rating store, column walk with one shared multiplier, serial finish
// a rating write is taken in the idle state and gives no result
// equal rows go straight to the output state, a pair with no columns first through the check state
// other queries walk the n columns in use:
//   two reads on one memory port and three products through one multiplier per column,
//   then two square roots, one multiply and one divide in the serial unit
// after reset the store is cleared one entry a cycle, all ROW_CNT*COL_CNT entries, ready low
`default_nettype none
module row_pair_cosine_similarity_core
    import rpcs_pkg::*;
#(
    parameter int ROW_CNT     = ROW_CNT_DEF,
    parameter int COL_CNT     = COL_CNT_DEF,
    parameter int RATING_BITS = RATING_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    rpcs_in_if.sink               i_req,
    rpcs_out_if.source            o_rsp
);
    localparam int ACC_W  = 2 * RATING_BITS + $clog2(COL_CNT);
    localparam int SQ_W   = (ACC_W + 1) / 2;
    localparam int DEN_W  = 2 * SQ_W;
    localparam int NUM_W  = ACC_W + FRAC_BITS;
    localparam int DEPTH  = ROW_CNT * COL_CNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(COL_CNT + 1);
    localparam int PW     = 2 * RATING_BITS;

    t_state r_state, n_state;

    logic [CFG_W-1:0]              r_cols;
    logic [ADDR_W-1:0]             r_clr;
    logic [ROW_W-1:0]              r_ra, r_rb;
    logic                          r_a_oob, r_b_oob;
    logic [CW-1:0]                 r_n, r_col;
    logic signed [RATING_BITS-1:0] r_opa, r_opb;
    logic signed [PW-1:0]          r_prod;
    logic                          r_pv;
    t_acc_sel                      r_pdst;
    logic signed [ACC_W-1:0]       r_dot;
    logic [ACC_W-1:0]              r_sa, r_sb, r_mag;
    logic                          r_neg;
    logic [SQ_W-1:0]               r_na, r_nb;
    logic [DEN_W-1:0]              r_den;
    logic signed [SIM_W-1:0]       r_res_sim;
    logic                          r_res_zn;
    logic                          r_out_vld;
    logic signed [SIM_W-1:0]       r_out_sim;
    logic                          r_out_zn;

    logic                          s_acc;
    logic [CW-1:0]                 s_n;
    logic                          s_ram_we;
    logic [ADDR_W-1:0]             s_waddr, s_raddr, s_req_addr;
    logic [RATING_BITS-1:0]        s_wdata, s_req_data, s_rdata;
    logic                          s_req_ok;
    logic [ROW_W-1:0]              s_rd_row;
    logic signed [RATING_BITS-1:0] s_mx, s_my;
    logic signed [PW-1:0]          s_prod;
    t_unit_ctl                     s_unit_ctl;
    t_unit_sts                     s_unit_sts;
    logic [NUM_W-1:0]              s_opnd_w, s_unit_res;
    logic [DEN_W-1:0]              s_opnd_d;
    logic [SIM_W-1:0]              s_q_mag;
    logic                          s_out_load;

    assign s_acc      = i_req.valid && i_req.ready;
    assign s_n        = (32'(r_cols) > COL_CNT) ? CW'(COL_CNT) : CW'(r_cols);
    assign s_req_addr = ADDR_W'(32'(i_req.row_a) * COL_CNT + 32'(i_req.column));
    assign s_req_ok   = (32'(i_req.row_a) < ROW_CNT) && (32'(i_req.column) < COL_CNT);
    assign s_req_data = RATING_BITS'(32'(i_req.rating));
    assign s_rd_row   = (r_state == S_RDA) ? r_ra : r_rb;
    assign s_raddr    = ADDR_W'(32'(s_rd_row) * COL_CNT + 32'(r_col));
    assign s_prod     = s_mx * s_my;
    assign s_out_load = (r_state == S_OUT) && (!r_out_vld || o_rsp.ready);

    always_comb begin
        if (32'(s_unit_res) > ONE_Q14) begin
            s_q_mag = SIM_W'(ONE_Q14);
        end else begin
            s_q_mag = s_unit_res[SIM_W-1:0];
        end
    end

    rpcs_ram #(
        .WIDTH (RATING_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_ram_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    rpcs_serial_unit #(
        .ACC_W (ACC_W)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_unit_ctl),
        .o_sts    (s_unit_sts),
        .i_opnd_w (s_opnd_w),
        .i_opnd_d (s_opnd_d),
        .o_result (s_unit_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (32'(r_clr) == DEPTH - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc && i_req.op == OP_QUERY) begin
                    if (i_req.row_a == i_req.row_b) n_state = S_OUT;
                    else if (s_n == '0)             n_state = S_CHK;
                    else                            n_state = S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: n_state = S_MAA;
            S_MAA: n_state = S_MBB;
            S_MBB: n_state = S_MAB;
            S_MAB: begin
                if (32'(r_col) + 1 == 32'(r_n)) n_state = S_DRAIN;
                else                            n_state = S_RDA;
            end
            S_DRAIN: n_state = S_CHK;
            S_CHK: begin
                if (r_sa == '0 || r_sb == '0) n_state = S_OUT;
                else                          n_state = S_SQA;
            end
            S_SQA:   n_state = S_SQA_W;
            S_SQA_W: if (s_unit_sts.done) n_state = S_SQB;
            S_SQB:   n_state = S_SQB_W;
            S_SQB_W: if (s_unit_sts.done) n_state = S_MUL;
            S_MUL:   n_state = S_MUL_W;
            S_MUL_W: if (s_unit_sts.done) n_state = S_DIV;
            S_DIV:   n_state = S_DIV_W;
            S_DIV_W: if (s_unit_sts.done) n_state = S_OUT;
            S_OUT:   if (s_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_req.ready      = 1'b0;
        s_ram_we         = 1'b0;
        s_waddr          = s_req_addr;
        s_wdata          = s_req_data;
        s_mx             = r_opa;
        s_my             = r_opa;
        s_unit_ctl.start = 1'b0;
        s_unit_ctl.op    = UOP_SQRT;
        s_opnd_w         = NUM_W'(r_sa);
        s_opnd_d         = r_den;
        unique case (r_state)
            S_CLEAR: begin
                s_ram_we = 1'b1;
                s_waddr  = r_clr;
                s_wdata  = '0;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                s_ram_we    = i_req.valid && i_req.op == OP_WRITE && s_req_ok;
            end
            S_MBB: begin
                s_mx = r_opb;
                s_my = r_opb;
            end
            S_MAB: begin
                s_my = r_opb;
            end
            S_SQA: begin
                s_unit_ctl.start = 1'b1;
            end
            S_SQB: begin
                s_unit_ctl.start = 1'b1;
                s_opnd_w         = NUM_W'(r_sb);
            end
            S_MUL: begin
                s_unit_ctl.start = 1'b1;
                s_unit_ctl.op    = UOP_MUL;
                s_opnd_w         = NUM_W'(r_nb);
                s_opnd_d         = DEN_W'(r_na);
            end
            S_DIV: begin
                s_unit_ctl.start = 1'b1;
                s_unit_ctl.op    = UOP_DIV;
                s_opnd_w         = NUM_W'(r_mag) << FRAC_BITS;
            end
            default: begin
                s_ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cols    <= CFG_COLS_RESET;
            r_clr     <= '0;
            r_pv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cols <= i_cfg_wdata;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            r_pv <= (r_state == S_MAA) || (r_state == S_MBB) || (r_state == S_MAB);
            if (s_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_acc) begin
            r_ra      <= i_req.row_a;
            r_rb      <= i_req.row_b;
            r_a_oob   <= 32'(i_req.row_a) >= ROW_CNT;
            r_b_oob   <= 32'(i_req.row_b) >= ROW_CNT;
            r_n       <= s_n;
            r_col     <= '0;
            r_dot     <= '0;
            r_sa      <= '0;
            r_sb      <= '0;
            r_res_sim <= SIM_W'(ONE_Q14);
            r_res_zn  <= 1'b0;
        end else if (r_pv) begin
            case (r_pdst)
                ACC_SA:  r_sa  <= r_sa + ACC_W'(r_prod);
                ACC_SB:  r_sb  <= r_sb + ACC_W'(r_prod);
                ACC_DOT: r_dot <= r_dot + ACC_W'(r_prod);
                default: r_dot <= r_dot;
            endcase
        end

        case (r_state)
            S_RDB: r_opa <= r_a_oob ? '0 : s_rdata;
            S_MAA: begin
                r_opb  <= r_b_oob ? '0 : s_rdata;
                r_prod <= s_prod;
                r_pdst <= ACC_SA;
            end
            S_MBB: begin
                r_prod <= s_prod;
                r_pdst <= ACC_SB;
            end
            S_MAB: begin
                r_prod <= s_prod;
                r_pdst <= ACC_DOT;
                r_col  <= r_col + 1'b1;
            end
            S_CHK: begin
                r_neg <= r_dot < 0;
                r_mag <= (r_dot < 0) ? ACC_W'(-r_dot) : ACC_W'(r_dot);
                if (r_sa == '0 || r_sb == '0) begin
                    r_res_sim <= '0;
                    r_res_zn  <= 1'b1;
                end
            end
            S_SQA_W: if (s_unit_sts.done) r_na  <= s_unit_res[SQ_W-1:0];
            S_SQB_W: if (s_unit_sts.done) r_nb  <= s_unit_res[SQ_W-1:0];
            S_MUL_W: if (s_unit_sts.done) r_den <= s_unit_res[DEN_W-1:0];
            S_DIV_W: begin
                if (s_unit_sts.done) begin
                    r_res_sim <= r_neg ? -$signed(s_q_mag) : $signed(s_q_mag);
                    r_res_zn  <= 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (s_out_load) begin
            r_out_sim <= r_res_sim;
            r_out_zn  <= r_res_zn;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.similarity = r_out_sim;
    assign o_rsp.zero_norm  = r_out_zn;

    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_CLEAR) |-> !s_ram_we)
        else $error("store written during a query");

    a_unit_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_unit_ctl.start |-> !s_unit_sts.busy)
        else $error("serial unit started while busy");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.similarity <= 16'sd16384 && o_rsp.similarity >= -16'sd16384))
        else $error("similarity out of range");

    a_zero_norm_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.zero_norm) |-> (o_rsp.similarity == '0))
        else $error("zero norm transaction with nonzero similarity");
endmodule
`default_nettype wire
